// ===== sv/jsim_pkg.sv =====
// Shared constants, types and control records of the jet similarity core.
// No dependencies; every other file but jsim_if imports this package.
package jsim_pkg;

  localparam int SCALES    = 5;
  localparam int ROTATIONS = 12;
  localparam int JET_SIZE  = SCALES * ROTATIONS;

  localparam int VAL_W  = 16;
  localparam int IDX_W  = (JET_SIZE > 1) ? $clog2(JET_SIZE) : 1;
  localparam int POS_W  = $clog2(JET_SIZE + 1);
  localparam int SHF_W  = $clog2(ROTATIONS);
  // Exact sums of 32-bit products over the whole jet.
  localparam int ACC_W  = 2 * VAL_W + IDX_W;
  localparam int PROD_W = 2 * ACC_W;
  // Squared score never exceeds 2^30, its root never exceeds 2^15.
  localparam int QUO_W  = 31;
  localparam int ROOT_W = 16;
  localparam int ROOT_OP_W = 32;
  localparam int STEP_W = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_TURN
  } cell_op_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        norm1;
    logic [ACC_W-1:0]        norm2;
  } score_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] score;
  } score_rsp_t;

endpackage

// ===== sv/jsim_if.sv =====
// Valid/ready channel interfaces for the jet similarity core.
// Depends on nothing; payload widths follow the item fields.
interface jsim_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_jet_value;
  logic signed [15:0] second_jet_value;
  logic               last_element;

  modport source (output valid, first_jet_value, second_jet_value, last_element,
                  input ready);
  modport sink   (input valid, first_jet_value, second_jet_value, last_element,
                  output ready);
endinterface

interface jsim_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] best_similarity;

  modport source (output valid, best_similarity, input ready);
  modport sink   (input valid, best_similarity, output ready);
endinterface

// ===== sv/jsim_cell.sv =====
// One storage cell of the jet chain: holds one element pair of both jets.
// Depends on jsim_pkg.
module jsim_cell (
  input  logic                              clk,
  input  jsim_pkg::cell_op_t                op,
  input  logic signed [jsim_pkg::VAL_W-1:0] wr_a,
  input  logic signed [jsim_pkg::VAL_W-1:0] wr_b,
  input  logic signed [jsim_pkg::VAL_W-1:0] next_a,
  input  logic signed [jsim_pkg::VAL_W-1:0] next_b,
  input  logic signed [jsim_pkg::VAL_W-1:0] row_b,
  output logic signed [jsim_pkg::VAL_W-1:0] a,
  output logic signed [jsim_pkg::VAL_W-1:0] b
);
  import jsim_pkg::*;

  logic signed [VAL_W-1:0] a_r;
  logic signed [VAL_W-1:0] b_r;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LOAD: begin
        a_r <= wr_a;
        b_r <= wr_b;
      end
      CELL_SHIFT: begin
        a_r <= next_a;
        b_r <= next_b;
      end
      CELL_TURN: begin
        b_r <= row_b;
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  assign a = a_r;
  assign b = b_r;

endmodule

// ===== sv/jsim_score.sv =====
// Iterative score unit: serial multiplier, restoring divider and bitwise square root.
// Turns one shift's dot product and norms into an unsigned Q1.15 cosine. Depends on jsim_pkg.
module jsim_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jsim_pkg::score_req_t req,
  output jsim_pkg::score_rsp_t rsp
);
  import jsim_pkg::*;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MULP,
    SC_MULD,
    SC_DIV,
    SC_ROOT
  } sc_state_t;

  sc_state_t            state_r;
  logic                 done_r;
  logic [STEP_W-1:0]    step_r;
  logic [PROD_W-1:0]    mcand_r;
  logic [ACC_W-1:0]     mplier_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     mag_r;
  logic [PROD_W-1:0]    p_r;
  logic                 lsb_r;
  logic [PROD_W-1:0]    rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic [ROOT_OP_W-1:0] op_r;
  logic [ROOT_OP_W-1:0] res_r;
  logic [ROOT_OP_W-1:0] one_r;
  logic [ROOT_W-1:0]    score_r;

  logic [PROD_W-1:0]    prod_nxt;
  logic [PROD_W:0]      trial;
  logic                 sub_ok;
  logic [PROD_W-1:0]    rem_nxt;
  logic [QUO_W-1:0]     quo_nxt;
  logic [ROOT_OP_W-1:0] sum;
  logic                 root_ok;
  logic [ROOT_OP_W-1:0] res_nxt;
  logic                 skip;

  assign prod_nxt = mplier_r[0] ? prod_r + mcand_r : prod_r;

  assign trial   = {rem_r, (step_r == '0) ? lsb_r : 1'b0};
  assign sub_ok  = trial >= {1'b0, p_r};
  assign rem_nxt = sub_ok ? PROD_W'(trial - {1'b0, p_r}) : trial[PROD_W-1:0];
  assign quo_nxt = {quo_r[QUO_W-2:0], sub_ok};

  assign sum     = res_r + one_r;
  assign root_ok = op_r >= sum;
  assign res_nxt = root_ok ? ((res_r >> 1) + one_r) : (res_r >> 1);

  // Non-positive dot or an empty norm scores zero at once.
  assign skip = req.dot[ACC_W-1] || (req.dot == '0) || (req.norm1 == '0)
                || (req.norm2 == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SC_IDLE: begin
          if (req.start) begin
            if (skip) begin
              score_r <= '0;
              done_r  <= 1'b1;
            end else begin
              mcand_r  <= PROD_W'(req.norm1);
              mplier_r <= req.norm2;
              prod_r   <= '0;
              mag_r    <= req.dot;
              step_r   <= '0;
              state_r  <= SC_MULP;
            end
          end
        end
        SC_MULP: begin
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          prod_r   <= prod_nxt;
          step_r   <= step_r + 1'b1;
          if (step_r == STEP_W'(ACC_W - 1)) begin
            p_r      <= prod_nxt;
            mcand_r  <= PROD_W'(mag_r);
            mplier_r <= mag_r;
            prod_r   <= '0;
            step_r   <= '0;
            state_r  <= SC_MULD;
          end
        end
        SC_MULD: begin
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          prod_r   <= prod_nxt;
          step_r   <= step_r + 1'b1;
          if (step_r == STEP_W'(ACC_W - 1)) begin
            // Divide dot^2 * 2^30 by norm1*norm2: preload the top, feed the rest.
            rem_r   <= prod_nxt >> 1;
            lsb_r   <= prod_nxt[0];
            step_r  <= '0;
            state_r <= SC_DIV;
          end
        end
        SC_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(QUO_W - 1)) begin
            op_r    <= ROOT_OP_W'(quo_nxt);
            res_r   <= '0;
            one_r   <= ROOT_OP_W'(1) << (ROOT_OP_W - 2);
            step_r  <= '0;
            state_r <= SC_ROOT;
          end
        end
        SC_ROOT: begin
          if (root_ok) begin
            op_r <= op_r - sum;
          end
          res_r  <= res_nxt;
          one_r  <= one_r >> 2;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(ROOT_W - 1)) begin
            score_r <= res_nxt[ROOT_W-1:0];
            done_r  <= 1'b1;
            state_r <= SC_IDLE;
          end
        end
        default: begin
          state_r <= SC_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.score = score_r;

endmodule

// ===== sv/rotation_shift_jet_similarity_core.sv =====
// Top level of the rotation-shift jet similarity core.
// Depends on jsim_pkg, jsim_if, jsim_cell and jsim_score.
//
// Usage:
//   in_if  (sink):   one element pair of both jets per item, scale-major. An item
//                    with last_element set closes the load and starts scoring.
//                    Pairs beyond SCALES*ROTATIONS before the mark are dropped.
//   out_if (source): one item per load, best_similarity in unsigned Q1.15
//                    (32768 = 1.0), the best cosine over all orientation shifts,
//                    clamped below at zero.
//   Loading accepts an item in every cycle that in_if.valid is high. After the last
//   item the block scores each of the ROTATIONS shifts in turn: the chain of cells
//   circulates once through a single multiply-accumulate, turns the second jet by one
//   orientation, then the score unit runs its serial multiplier twice, its divider
//   and its square root. During all of this in_if.ready stays low.
//   The result sits in an output register; the block reopens for loading while it
//   waits, and only holds a finished score when the previous one is still untaken.
//   Reset (rst_n low, synchronous) clears control state and the load position;
//   the jet contents are undefined until loaded.
module rotation_shift_jet_similarity_core (
  input  logic clk,
  input  logic rst_n,
  jsim_in_if.sink    in_if,
  jsim_out_if.source out_if
);
  import jsim_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MAC,
    ST_TURN,
    ST_KICK,
    ST_WAIT,
    ST_DONE
  } state_t;

  state_t                  state_r;
  logic [POS_W-1:0]        pos_r;
  logic [IDX_W-1:0]        cnt_r;
  logic [SHF_W-1:0]        shift_r;
  logic                    p_vld_r;
  logic signed [31:0]      prod_ab_r;
  logic [31:0]             prod_aa_r;
  logic [31:0]             prod_bb_r;
  logic signed [ACC_W-1:0] dot_r;
  logic [ACC_W-1:0]        n1_r;
  logic [ACC_W-1:0]        n2_r;
  logic [ROOT_W-1:0]       best_r;
  logic                    out_valid_r;
  logic [ROOT_W-1:0]       out_data_r;
  logic                    start_r;

  logic signed [VAL_W-1:0] cell_a [JET_SIZE];
  logic signed [VAL_W-1:0] cell_b [JET_SIZE];
  cell_op_t                cell_op [JET_SIZE];
  logic signed [31:0]      head_a;
  logic signed [31:0]      head_b;
  logic                    in_acc;
  score_req_t              req;
  score_rsp_t              rsp;

  assign in_if.ready = (state_r == ST_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;

  // Chain of cells: shift toward the head, turn each scale row of the second jet.
  for (genvar k = 0; k < JET_SIZE; k++) begin : g_cell
    localparam int ROW = k / ROTATIONS;
    localparam int COL = k % ROTATIONS;

    always_comb begin
      cell_op[k] = CELL_HOLD;
      priority if (state_r == ST_MAC) begin
        cell_op[k] = CELL_SHIFT;
      end else if (state_r == ST_TURN) begin
        cell_op[k] = CELL_TURN;
      end else if (in_acc && (pos_r < POS_W'(JET_SIZE))
                   && (pos_r[IDX_W-1:0] == IDX_W'(k))) begin
        cell_op[k] = CELL_LOAD;
      end
    end

    jsim_cell u_cell (
      .clk    (clk),
      .op     (cell_op[k]),
      .wr_a   (in_if.first_jet_value),
      .wr_b   (in_if.second_jet_value),
      .next_a (cell_a[(k + 1) % JET_SIZE]),
      .next_b (cell_b[(k + 1) % JET_SIZE]),
      .row_b  (cell_b[ROW * ROTATIONS + (COL + 1) % ROTATIONS]),
      .a      (cell_a[k]),
      .b      (cell_b[k])
    );
  end

  assign head_a = 32'(cell_a[0]);
  assign head_b = 32'(cell_b[0]);

  assign req.start = start_r;
  assign req.dot   = dot_r;
  assign req.norm1 = n1_r;
  assign req.norm2 = n2_r;

  jsim_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Product stage: register the head pair's products each cycle of a pass.
  always_ff @(posedge clk) begin
    prod_ab_r <= head_a * head_b;
    prod_aa_r <= 32'(head_a * head_a);
    prod_bb_r <= 32'(head_b * head_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      cnt_r       <= '0;
      shift_r     <= '0;
      p_vld_r     <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      p_vld_r <= (state_r == ST_MAC);

      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      // Accumulate stage; norms do not depend on the shift, so take them once.
      if (p_vld_r) begin
        dot_r <= dot_r + ACC_W'(prod_ab_r);
        if (shift_r == '0) begin
          n1_r <= n1_r + ACC_W'(prod_aa_r);
          n2_r <= n2_r + ACC_W'(prod_bb_r);
        end
      end

      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (pos_r < POS_W'(JET_SIZE)) begin
              pos_r <= pos_r + 1'b1;
            end
            if (in_if.last_element) begin
              pos_r   <= '0;
              cnt_r   <= '0;
              shift_r <= '0;
              dot_r   <= '0;
              n1_r    <= '0;
              n2_r    <= '0;
              best_r  <= '0;
              state_r <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(JET_SIZE - 1)) begin
            state_r <= ST_TURN;
          end
        end
        ST_TURN: begin
          state_r <= ST_KICK;
        end
        ST_KICK: begin
          start_r <= 1'b1;
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            if (rsp.score > best_r) begin
              best_r <= rsp.score;
            end
            if (shift_r == SHF_W'(ROTATIONS - 1)) begin
              state_r <= ST_DONE;
            end else begin
              shift_r <= shift_r + 1'b1;
              cnt_r   <= '0;
              dot_r   <= '0;
              state_r <= ST_MAC;
            end
          end
        end
        ST_DONE: begin
          // Hold the score until the output register is free.
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= best_r;
            state_r     <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.best_similarity = out_data_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the rotation-shift jet similarity core.
// Depends on jsim_pkg, jsim_if and the core; drives jet loads, predicts each best score.
`timescale 1ns / 100ps

module tb_top;
  import jsim_pkg::*;

  localparam int TARGET_ITEMS = 1950;
  localparam int STALL_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 8000;
  localparam int DRAIN_CYCLES = 3000;

  typedef struct {
    logic signed [15:0] first_val;
    logic signed [15:0] second_val;
    logic               last;
    bit                 drain;
  } pair_item_t;

  typedef enum int { FILL_RANDOM, FILL_SMALL, FILL_ROTATED } fill_mode_t;

  logic clk;
  logic rst_n;

  jsim_in_if  in_ch();
  jsim_out_if out_ch();

  rotation_shift_jet_similarity_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pair_item_t pending_pairs[$];
  logic [15:0] expected_scores[$];

  // Own copy of the jet stores and load position.
  logic signed [15:0] first_jet[JET_SIZE];
  logic signed [15:0] second_jet[JET_SIZE];
  int                 load_pos;

  int  errors;
  int  pushed_items;
  int  accepted_items;
  int  results_seen;
  int  quiet_cycles;
  int  hold_cnt;
  bit  hold_done;
  bit  in_taken;
  bit  offer_held;
  int  phase;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Largest q in 0..32768 with q^2 * n1 * n2 <= 2^30 * dot^2.
  function automatic logic [15:0] cosine_q15(longint dot, longint n1, longint n2);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] mid;
    logic [127:0] lo;
    logic [127:0] hi;
    if (n1 == 0 || n2 == 0 || dot <= 0) return 16'd0;
    rhs = 128'(dot) * 128'(dot);
    rhs = rhs << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = mid * mid * 128'(n1) * 128'(n2);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic logic [15:0] best_shift_score();
    logic [15:0] best;
    logic [15:0] sc;
    longint dot;
    longint n1;
    longint n2;
    longint a;
    longint b;
    best = 0;
    for (int s = 0; s < ROTATIONS; s++) begin
      dot = 0;
      n1 = 0;
      n2 = 0;
      for (int i = 0; i < SCALES; i++) begin
        for (int j = 0; j < ROTATIONS; j++) begin
          a = first_jet[i*ROTATIONS + j];
          b = second_jet[i*ROTATIONS + (j + s) % ROTATIONS];
          dot += a * b;
          n1 += a * a;
          n2 += b * b;
        end
      end
      sc = cosine_q15(dot, n1, n2);
      if (sc > best) best = sc;
    end
    return best;
  endfunction

  task automatic push_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
                           bit drain = 0);
    pair_item_t it;
    it.first_val = a;
    it.second_val = b;
    it.last = last;
    it.drain = drain;
    pending_pairs.insert(pending_pairs.size(), it);
    pushed_items++;
  endtask

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Queue one load of n pairs; the last one carries the mark.
  task automatic push_load(int n, fill_mode_t mode, bit drain = 0);
    logic signed [15:0] a[JET_SIZE];
    logic signed [15:0] b;
    int rot;
    rot = $urandom_range(0, ROTATIONS - 1);
    for (int k = 0; k < JET_SIZE; k++) begin
      if (mode == FILL_SMALL) a[k] = sat16($urandom_range(0, 511) - 256);
      else a[k] = 16'($urandom);
    end
    for (int k = 0; k < n; k++) begin
      int idx;
      int i;
      int j;
      idx = k % JET_SIZE;
      i = idx / ROTATIONS;
      j = idx % ROTATIONS;
      case (mode)
        FILL_ROTATED: b = sat16(int'(a[i*ROTATIONS + (j + rot) % ROTATIONS])
                                + $urandom_range(0, 2047) - 1024);
        FILL_SMALL:   b = sat16($urandom_range(0, 511) - 256);
        default:      b = 16'($urandom);
      endcase
      push_pair(a[idx], b, k == n - 1, drain && k == 0);
    end
  endtask

  // Stimulus: directed loads, then random loads.
  initial begin
    logic signed [15:0] v;
    int r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_jet_value = '0;
    in_ch.second_jet_value = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    pushed_items = 0;
    accepted_items = 0;
    results_seen = 0;
    quiet_cycles = 0;
    hold_cnt = 0;
    hold_done = 0;
    in_taken = 0;
    offer_held = 0;
    phase = 0;
    load_pos = 0;

    // Full first load at the field extremes, so every entry is written.
    for (int k = 0; k < JET_SIZE; k++)
      push_pair((k % 2) ? -16'sd32768 : 16'sd32767, (k % 3) ? 16'sd32767 : -16'sd32768,
                k == JET_SIZE - 1);
    // Identical jets: perfect score.
    for (int k = 0; k < JET_SIZE; k++) begin
      v = 16'($urandom);
      push_pair(v, v, k == JET_SIZE - 1);
    end
    // Opposite jets: negative dot on the aligned shift.
    for (int k = 0; k < JET_SIZE; k++) begin
      v = 16'($urandom);
      push_pair(v, sat16(-int'(v)), k == JET_SIZE - 1);
    end
    // First jet all zero: zero norm on every shift.
    for (int k = 0; k < JET_SIZE; k++)
      push_pair(16'sd0, 16'($urandom), k == JET_SIZE - 1);
    // Overlong load, then early marks that keep older entries.
    push_load(JET_SIZE + 6, FILL_RANDOM);
    push_load(7, FILL_RANDOM);
    push_load(1, FILL_SMALL);

    while (pushed_items < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 35) push_load(JET_SIZE, FILL_ROTATED, pushed_items > 900 && pushed_items < 960);
      else if (r < 60) push_load(JET_SIZE, FILL_RANDOM);
      else if (r < 75) push_load(JET_SIZE, FILL_SMALL);
      else if (r < 87) push_load($urandom_range(JET_SIZE + 1, JET_SIZE + 15), FILL_RANDOM);
      else push_load($urandom_range(1, JET_SIZE - 1), FILL_ROTATED);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_pairs.size() > 0 || expected_scores.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Monitor: update the predictor on input items, check result items, watch for hangs.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      phase = (accepted_items * 4) / TARGET_ITEMS;
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        in_taken = 1;
        accepted_items++;
        if (load_pos < JET_SIZE) begin
          first_jet[load_pos] = in_ch.first_jet_value;
          second_jet[load_pos] = in_ch.second_jet_value;
          load_pos++;
        end
        if (in_ch.last_element) begin
          load_pos = 0;
          expected_scores.insert(expected_scores.size(), best_shift_score());
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_scores.size() == 0) begin
          report_mismatch("unexpected best_similarity", out_ch.best_similarity, -1);
        end else begin
          if (out_ch.best_similarity !== expected_scores[0])
            report_mismatch("best_similarity", out_ch.best_similarity, expected_scores[0]);
          void'(expected_scores.pop_front());
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item accepted for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Driver: hold an offered item until taken, idle at random by phase.
  always @(negedge clk) begin
    int idle_pct;
    bit offer;
    bit popped;
    if (rst_n) begin
      popped = 0;
      if (in_taken) begin
        void'(pending_pairs.pop_front());
        in_taken = 0;
        popped = 1;
      end
      idle_pct = (phase == 1) ? 53 : (phase == 3) ? 36 : 0;
      if (hold_cnt > 0) idle_pct = 0;
      if (offer_held && !popped) begin
        offer = 1;
      end else begin
        offer = pending_pairs.size() > 0
                && !(pending_pairs[0].drain && expected_scores.size() > 0)
                && $urandom_range(0, 99) >= idle_pct;
      end
      offer_held = offer;
      if (offer) begin
        in_ch.first_jet_value = pending_pairs[0].first_val;
        in_ch.second_jet_value = pending_pairs[0].second_val;
        in_ch.last_element = pending_pairs[0].last;
      end
      in_ch.valid = offer;
    end
  end

  // Receiver: random stalls by phase, and one long hold-off so the core backs up.
  always @(negedge clk) begin
    int stall_pct;
    if (rst_n) begin
      if (!hold_done && results_seen >= 4) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1;
      end
      stall_pct = (phase == 2) ? 53 : (phase == 3) ? 36 : 0;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = $urandom_range(0, 99) >= stall_pct;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/jsim_pkg.sv
sv/jsim_if.sv
sv/jsim_cell.sv
sv/jsim_score.sv
sv/rotation_shift_jet_similarity_core.sv
verif/tb_top.sv
